// ===== rtl/core/plte_pkg.sv =====
package plte_pkg;

    localparam int MAX_NODES   = 256;
    localparam int NODE_AW     = $clog2(MAX_NODES);
    localparam int COUNT_W     = 9;
    localparam int DATA_W      = 32;
    localparam int CFG_AW      = 2;
    localparam int REGION_W    = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int MUL_STEPS   = DATA_W;
    localparam int PROD_W      = 2 * DATA_W + 1;
    localparam int DIV_STEPS   = PROD_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    localparam logic [REGION_W-1:0] REGION_INTERP = 2'd0;
    localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd1;
    localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_NODE_COUNT    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_DEFAULT_BELOW = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_DEFAULT_ABOVE = 2'd2;

    typedef struct packed {
        logic                      mode;
        logic [NODE_AW-1:0]        index;
        logic signed [DATA_W-1:0]  x;
        logic signed [DATA_W-1:0]  y;
    } plte_item_t;

endpackage

// ===== rtl/core/piecewise_linear_table_eval.sv =====
// load beat: one per cycle while the back end is idle, via front register and queue slot
// into the node table; evaluate beat: above the last node gives default_above, below the
// first node default_below, at the first node its y, else interpolation by the node search,
// the 32-step shift-add multiply and the 65-step restoring divide; the back end works one
// evaluate at a time; a 2-beat queue decouples it from the front
// reset: handshake and sequencer state cleared, node_count 2, defaults 0, table undefined
module piecewise_linear_table_eval
    import plte_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_AW-1:0]    cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [NODE_AW-1:0]   node_index,
    input  logic [DATA_W-1:0]    x_value,
    input  logic [DATA_W-1:0]    y_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_W-1:0]    result_value,
    output logic [REGION_W-1:0]  region
);

    logic [COUNT_W-1:0] node_count_reg, node_count_next;
    logic [DATA_W-1:0]  default_below_reg, default_below_next;
    logic [DATA_W-1:0]  default_above_reg, default_above_next;

    plte_item_t         front_item;
    logic               front_valid;
    logic               front_ready;
    plte_item_t         queue_item;
    logic               queue_valid;
    logic               queue_ready;

    always_comb
    begin
        node_count_next    = node_count_reg;
        default_below_next = default_below_reg;
        default_above_next = default_above_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_NODE_COUNT:    node_count_next    = cfg_data[COUNT_W-1:0];
                CFG_DEFAULT_BELOW: default_below_next = cfg_data;
                CFG_DEFAULT_ABOVE: default_above_next = cfg_data;
                default:           node_count_next    = node_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg    <= COUNT_W'(2);
            default_below_reg <= '0;
            default_above_reg <= '0;
        end
        else
        begin
            node_count_reg    <= node_count_next;
            default_below_reg <= default_below_next;
            default_above_reg <= default_above_next;
        end
    end

    plte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .node_index (node_index),
        .x_value    (x_value),
        .y_value    (y_value),
        .node_count (node_count_reg),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    plte_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    plte_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (queue_valid),
        .item_ready    (queue_ready),
        .item          (queue_item),
        .default_below (default_below_reg),
        .default_above (default_above_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_value  (result_value),
        .region        (region)
    );

endmodule

// ===== rtl/core/plte_front.sv =====
module plte_front
    import plte_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [NODE_AW-1:0]  node_index,
    input  logic [DATA_W-1:0]   x_value,
    input  logic [DATA_W-1:0]   y_value,
    input  logic [COUNT_W-1:0]  node_count,
    output logic                item_valid,
    input  logic                item_ready,
    output plte_item_t          item
);

    logic               hold_valid_reg;
    logic               hold_valid_next;
    plte_item_t         item_reg;
    plte_item_t         item_next;
    logic [COUNT_W-1:0] last_wide;
    logic [NODE_AW-1:0] last_index;
    logic               accept;

    assign in_ready   = !hold_valid_reg || item_ready;
    assign accept     = in_valid && in_ready;
    assign item_valid = hold_valid_reg;
    assign item       = item_reg;

    // last node in use, count clamped to between 2 and the table size
    always_comb
    begin
        last_wide = node_count - COUNT_W'(1);
        if (node_count < COUNT_W'(2))
        begin
            last_index = NODE_AW'(1);
        end
        else if (node_count > COUNT_W'(MAX_NODES))
        begin
            last_index = NODE_AW'(MAX_NODES - 1);
        end
        else
        begin
            last_index = last_wide[NODE_AW-1:0];
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        item_next       = item_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
            item_next.mode  = mode;
            item_next.index = (mode == MODE_EVAL) ? last_index : node_index;
            item_next.x     = x_value;
            item_next.y     = y_value;
        end
        else if (item_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== rtl/core/plte_queue.sv =====
module plte_queue
    import plte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  plte_item_t  push_item,
    output logic        pop_valid,
    input  logic        pop_ready,
    output plte_item_t  pop_item
);

    plte_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/plte_back.sv =====
module plte_back
    import plte_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  plte_item_t            item,
    input  logic [DATA_W-1:0]     default_below,
    input  logic [DATA_W-1:0]     default_above,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_W-1:0]     result_value,
    output logic [REGION_W-1:0]   region
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_LAST   = 11'b00000000010,
        S_FIRST  = 11'b00000000100,
        S_SEARCH = 11'b00000001000,
        S_YA     = 11'b00000010000,
        S_YB     = 11'b00000100000,
        S_MAG    = 11'b00001000000,
        S_MUL    = 11'b00010000000,
        S_DIV    = 11'b00100000000,
        S_FIN    = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } plte_state_t;

    logic signed [DATA_W-1:0] x_mem [MAX_NODES];
    logic signed [DATA_W-1:0] y_mem [MAX_NODES];
    logic signed [DATA_W-1:0] x_rd_reg;
    logic signed [DATA_W-1:0] y_rd_reg;
    logic [NODE_AW-1:0]       x_raddr;
    logic [NODE_AW-1:0]       y_raddr;
    logic                     mem_we;
    logic                     pop;
    logic                     can_emit;

    plte_state_t              state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        result_reg, result_next;
    logic [REGION_W-1:0]      region_reg, region_next;

    logic signed [DATA_W-1:0] x_reg, x_next;
    logic [NODE_AW-1:0]       last_reg, last_next;
    logic [NODE_AW-1:0]       i_reg, i_next;
    logic signed [DATA_W-1:0] xa_reg, xa_next;
    logic signed [DATA_W-1:0] xb_reg, xb_next;
    logic signed [DATA_W-1:0] ya_reg, ya_next;
    logic signed [DATA_W:0]   dy_reg, dy_next;
    logic [DATA_W:0]          mag_reg, mag_next;
    logic [DATA_W-1:0]        dxq_reg, dxq_next;
    logic [DATA_W-1:0]        dx_reg, dx_next;
    logic [PROD_W-1:0]        p_reg, p_next;
    logic [DATA_W-1:0]        rem_reg, rem_next;
    logic [DATA_W-1:0]        res_pend_reg, res_pend_next;
    logic [REGION_W-1:0]      region_pend_reg, region_pend_next;

    logic [DATA_W+1:0]        mul_sum;
    logic [DATA_W:0]          div_shift;
    logic [DATA_W:0]          div_diff;
    logic                     div_ge;

    assign item_ready   = (state_reg == S_IDLE);
    assign pop          = item_valid && item_ready;
    assign mem_we       = pop && (item.mode == MODE_LOAD);
    assign can_emit     = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign region       = region_reg;

    // shift-add multiply step and restoring divide step
    assign mul_sum   = {1'b0, p_reg[PROD_W-1:DATA_W]} + (p_reg[0] ? {1'b0, mag_reg} : '0);
    assign div_shift = {rem_reg, p_reg[PROD_W-1]};
    assign div_diff  = div_shift - {1'b0, dx_reg};
    assign div_ge    = (div_shift >= {1'b0, dx_reg});

    always_comb
    begin
        x_raddr = '0;
        y_raddr = '0;
        case (state_reg)
            S_IDLE:   x_raddr = item.index;
            S_FIRST:  x_raddr = NODE_AW'(1);
            S_SEARCH:
            begin
                x_raddr = i_reg + NODE_AW'(1);
                y_raddr = i_reg - NODE_AW'(1);
            end
            S_YA:     y_raddr = i_reg;
            default:
            begin
                x_raddr = '0;
                y_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            x_mem[item.index] <= item.x;
            y_mem[item.index] <= item.y;
        end
        x_rd_reg <= x_mem[x_raddr];
        y_rd_reg <= y_mem[y_raddr];
    end

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        out_valid_next   = out_valid_reg;
        result_next      = result_reg;
        region_next      = region_reg;
        x_next           = x_reg;
        last_next        = last_reg;
        i_next           = i_reg;
        xa_next          = xa_reg;
        xb_next          = xb_reg;
        ya_next          = ya_reg;
        dy_next          = dy_reg;
        mag_next         = mag_reg;
        dxq_next         = dxq_reg;
        dx_next          = dx_reg;
        p_next           = p_reg;
        rem_next         = rem_reg;
        res_pend_next    = res_pend_reg;
        region_pend_next = region_pend_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pop && item.mode == MODE_EVAL)
                begin
                    x_next     = item.x;
                    last_next  = item.index;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (x_reg > x_rd_reg)
                begin
                    res_pend_next    = default_above;
                    region_pend_next = REGION_ABOVE;
                    state_next       = S_EMIT;
                end
                else
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (x_reg < x_rd_reg)
                begin
                    res_pend_next    = default_below;
                    region_pend_next = REGION_BELOW;
                    state_next       = S_EMIT;
                end
                else if (x_reg == x_rd_reg)
                begin
                    res_pend_next    = y_rd_reg;
                    region_pend_next = REGION_INTERP;
                    state_next       = S_EMIT;
                end
                else
                begin
                    xa_next    = x_rd_reg;
                    i_next     = NODE_AW'(1);
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if ((i_reg != last_reg) && (x_reg > x_rd_reg))
                begin
                    xa_next = x_rd_reg;
                    i_next  = i_reg + NODE_AW'(1);
                end
                else
                begin
                    xb_next    = x_rd_reg;
                    state_next = S_YA;
                end
            end
            S_YA:
            begin
                ya_next    = y_rd_reg;
                dxq_next   = x_reg - xa_reg;
                dx_next    = xb_reg - xa_reg;
                state_next = S_YB;
            end
            S_YB:
            begin
                dy_next    = {y_rd_reg[DATA_W-1], y_rd_reg} - {ya_reg[DATA_W-1], ya_reg};
                state_next = S_MAG;
            end
            S_MAG:
            begin
                mag_next   = dy_reg[DATA_W] ? (DATA_W+1)'(-dy_reg) : (DATA_W+1)'(dy_reg);
                p_next     = {(PROD_W-DATA_W)'(0), dxq_reg};
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                p_next    = {mul_sum, p_reg[DATA_W-1:1]};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    step_next  = '0;
                    rem_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
                p_next    = {p_reg[PROD_W-2:0], div_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                res_pend_next    = dy_reg[DATA_W] ? ya_reg - p_reg[DATA_W-1:0]
                                                  : ya_reg + p_reg[DATA_W-1:0];
                region_pend_next = REGION_INTERP;
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    result_next    = res_pend_reg;
                    region_next    = region_pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg      <= result_next;
        region_reg      <= region_next;
        x_reg           <= x_next;
        last_reg        <= last_next;
        i_reg           <= i_next;
        xa_reg          <= xa_next;
        xb_reg          <= xb_next;
        ya_reg          <= ya_next;
        dy_reg          <= dy_next;
        mag_reg         <= mag_next;
        dxq_reg         <= dxq_next;
        dx_reg          <= dx_next;
        p_reg           <= p_next;
        rem_reg         <= rem_next;
        res_pend_reg    <= res_pend_next;
        region_pend_reg <= region_pend_next;
    end

endmodule
